// ----- hw/rtl/rbt_pkg.sv -----
// Shared constants and types for the red-black tree find-or-insert block.
package rbt_pkg;

  localparam int unsigned InKeyW = 64;
  localparam int unsigned SlotW  = 10;
  localparam int unsigned OffW   = 23;
  localparam int unsigned ChunkW = 13;

  // Field write mask for one node store write.
  typedef struct packed {
    logic key;
    logic left;
    logic right;
    logic parent;
    logic red;
  } rbt_fmask_t;

endpackage

// ----- hw/rtl/rbt_key_if.sv -----
// Request channel carrying one key.
interface rbt_key_if;
  import rbt_pkg::*;
  logic              valid;
  logic              ready;
  logic [InKeyW-1:0] key;

  modport source (output valid, output key, input ready);
  modport sink   (input valid, input key, output ready);
endinterface

// ----- hw/rtl/rbt_res_if.sv -----
// Result channel carrying slot, byte offset and flags.
interface rbt_res_if;
  import rbt_pkg::*;
  logic             valid;
  logic             ready;
  logic [SlotW-1:0] slot;
  logic [OffW-1:0]  data_offset;
  logic             is_new;
  logic             full_res;

  modport source (output valid, output slot, output data_offset, output is_new,
                  output full_res, input ready);
  modport sink   (input valid, input slot, input data_offset, input is_new,
                  input full_res, output ready);
endinterface

// ----- hw/rtl/rbt_node_mem.sv -----
// Node store: key, links and color per slot, one read and one masked write port.
module rbt_node_mem
  import rbt_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic                         clk_i,
  input  logic                         rd_en_i,
  input  logic [$clog2(CAPACITY):0]    rd_addr_i,
  output logic [KEY_BITS-1:0]          rd_key_o,
  output logic [$clog2(CAPACITY):0]    rd_left_o,
  output logic [$clog2(CAPACITY):0]    rd_right_o,
  output logic [$clog2(CAPACITY):0]    rd_parent_o,
  output logic                         rd_red_o,
  input  logic                         wr_en_i,
  input  rbt_fmask_t                   wr_mask_i,
  input  logic [$clog2(CAPACITY):0]    wr_addr_i,
  input  logic [KEY_BITS-1:0]          wr_key_i,
  input  logic [$clog2(CAPACITY):0]    wr_left_i,
  input  logic [$clog2(CAPACITY):0]    wr_right_i,
  input  logic [$clog2(CAPACITY):0]    wr_parent_i,
  input  logic                         wr_red_i
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = AW + 1;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  logic [KEY_BITS-1:0] key_mem    [CAPACITY];
  logic [LW-1:0]       left_mem   [CAPACITY];
  logic [LW-1:0]       right_mem  [CAPACITY];
  logic [LW-1:0]       parent_mem [CAPACITY];
  logic                red_mem    [CAPACITY];

  logic [KEY_BITS-1:0] key_q;
  logic [LW-1:0]       left_q, right_q, parent_q;
  logic                red_q, nil_q;

  // Writes aimed at the null sentinel are dropped.
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_addr_i < NIL)) begin
      if (wr_mask_i.key)    key_mem[wr_addr_i[AW-1:0]]    <= wr_key_i;
      if (wr_mask_i.left)   left_mem[wr_addr_i[AW-1:0]]   <= wr_left_i;
      if (wr_mask_i.right)  right_mem[wr_addr_i[AW-1:0]]  <= wr_right_i;
      if (wr_mask_i.parent) parent_mem[wr_addr_i[AW-1:0]] <= wr_parent_i;
      if (wr_mask_i.red)    red_mem[wr_addr_i[AW-1:0]]    <= wr_red_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      nil_q    <= !(rd_addr_i < NIL);
      key_q    <= key_mem[rd_addr_i[AW-1:0]];
      left_q   <= left_mem[rd_addr_i[AW-1:0]];
      right_q  <= right_mem[rd_addr_i[AW-1:0]];
      parent_q <= parent_mem[rd_addr_i[AW-1:0]];
      red_q    <= red_mem[rd_addr_i[AW-1:0]];
    end
  end

  // The sentinel reads as a black node with null links.
  assign rd_key_o    = key_q;
  assign rd_left_o   = nil_q ? NIL : left_q;
  assign rd_right_o  = nil_q ? NIL : right_q;
  assign rd_parent_o = nil_q ? NIL : parent_q;
  assign rd_red_o    = nil_q ? 1'b0 : red_q;

endmodule

// ----- hw/rtl/rb_tree_find_or_insert_top.sv -----
// Top level of the red-black tree find-or-insert block.
//
// Each request on req_i carries one key. The block searches a red-black tree
// held in a node store and answers with one result on res_o: the slot of the
// key with is_new clear if it was present, or a freshly allocated slot (slots
// are handed out in insertion order) with is_new set after the insert fix-up.
// When the store is full, an absent key is not inserted and full_res is set.
// data_offset is slot times chunk_bytes, written over cfg_we_i / cfg_data_i.
// A found key keeps the block busy while it accepts the request, searches
// one tree level after another and loads the result register. An insert
// goes on to write and link the new node, read the node and its parent and
// paint the root black, with recoloring steps up the tree as needed. A
// fix-up that ends in rotations reads grandparent and uncle, recolors the
// parent and grandparent and rotates once or twice; a rotation at the root
// skips the write of the old parent's child link. Every access goes through
// the one read and one write port of the node store, one access per cycle.
// One request is worked on at a time; req_i.ready is high while idle.
// The finished result sits in an output register, so a new request is taken
// while the receiver stalls; only the next result waits for it to drain.
// Reset empties the tree (null root, zero count) and clears chunk_bytes.
module rb_tree_find_or_insert_top
  import rbt_pkg::*;
#(
  parameter int unsigned CAPACITY = 1024,
  parameter int unsigned KEY_BITS = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [ChunkW-1:0] cfg_data_i,
  rbt_key_if.sink           req_i,
  rbt_res_if.source         res_o
);
  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned LW = AW + 1;
  localparam logic [LW-1:0] NIL = LW'(CAPACITY);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SRCH = 5'd1;
  localparam logic [4:0] ST_INS  = 5'd2;
  localparam logic [4:0] ST_LINK = 5'd3;
  localparam logic [4:0] ST_FZ   = 5'd4;
  localparam logic [4:0] ST_FP0  = 5'd5;
  localparam logic [4:0] ST_FP   = 5'd6;
  localparam logic [4:0] ST_FG   = 5'd7;
  localparam logic [4:0] ST_FU   = 5'd8;
  localparam logic [4:0] ST_RC1  = 5'd9;
  localparam logic [4:0] ST_RC2  = 5'd10;
  localparam logic [4:0] ST_CW1  = 5'd11;
  localparam logic [4:0] ST_CW2  = 5'd12;
  localparam logic [4:0] ST_R0   = 5'd13;
  localparam logic [4:0] ST_R1   = 5'd14;
  localparam logic [4:0] ST_R2   = 5'd15;
  localparam logic [4:0] ST_R3   = 5'd16;
  localparam logic [4:0] ST_R4   = 5'd17;
  localparam logic [4:0] ST_R5   = 5'd18;
  localparam logic [4:0] ST_R6   = 5'd19;
  localparam logic [4:0] ST_R7   = 5'd20;
  localparam logic [4:0] ST_R8   = 5'd21;
  localparam logic [4:0] ST_ROOT = 5'd22;
  localparam logic [4:0] ST_DONE = 5'd23;

  logic [4:0]          state_q, state_d;
  logic [ChunkW-1:0]   chunk_q;
  logic [LW-1:0]       root_q, root_d, count_q, count_d;
  logic [KEY_BITS-1:0] key_q, key_d;
  logic [LW-1:0]       cur_q, cur_d, par_q, par_d;
  logic                left_q, left_d;
  logic [LW-1:0]       z_q, z_d, p_q, p_d, g_q, g_d, u_q, u_d;
  logic [LW-1:0]       pl_q, pl_d, pr_q, pr_d;
  logic                pleft_q, pleft_d;
  // Rotation working registers: pivot, lifted child, inner grandchild, parent.
  logic [LW-1:0]       rx_q, rx_d, ry_q, ry_d, rb_q, rb_d, rxp_q, rxp_d;
  logic                rr_q, rr_d, ret_q, ret_d;
  logic [LW-1:0]       rslot_q, rslot_d;
  logic                rnew_q, rnew_d, rfull_q, rfull_d;

  logic                res_valid_q;
  logic [SlotW-1:0]    res_slot_q;
  logic [OffW-1:0]     res_off_q;
  logic                res_new_q, res_full_q;
  logic                res_load;

  logic                rd_en;
  logic [LW-1:0]       rd_addr;
  logic [KEY_BITS-1:0] rd_key;
  logic [LW-1:0]       rd_left, rd_right, rd_parent;
  logic                rd_red;
  logic                wr_en;
  rbt_fmask_t          wr_mask;
  logic [LW-1:0]       wr_addr, wr_left, wr_right, wr_parent;
  logic                wr_red;
  logic [LW-1:0]       nxt, ychild;

  rbt_node_mem #(.CAPACITY(CAPACITY), .KEY_BITS(KEY_BITS)) u_mem (
    .clk_i       (clk_i),
    .rd_en_i     (rd_en),
    .rd_addr_i   (rd_addr),
    .rd_key_o    (rd_key),
    .rd_left_o   (rd_left),
    .rd_right_o  (rd_right),
    .rd_parent_o (rd_parent),
    .rd_red_o    (rd_red),
    .wr_en_i     (wr_en),
    .wr_mask_i   (wr_mask),
    .wr_addr_i   (wr_addr),
    .wr_key_i    (key_q),
    .wr_left_i   (wr_left),
    .wr_right_i  (wr_right),
    .wr_parent_i (wr_parent),
    .wr_red_i    (wr_red)
  );

  assign req_i.ready       = (state_q == ST_IDLE);
  assign res_o.valid       = res_valid_q;
  assign res_o.slot        = res_slot_q;
  assign res_o.data_offset = res_off_q;
  assign res_o.is_new      = res_new_q;
  assign res_o.full_res    = res_full_q;

  assign res_load = (state_q == ST_DONE) && (!res_valid_q || res_o.ready);
  assign nxt      = (key_q < rd_key) ? rd_left : rd_right;

  always_comb begin
    state_d = state_q;
    root_d  = root_q;   count_d = count_q;
    key_d   = key_q;    cur_d   = cur_q;   par_d = par_q;  left_d = left_q;
    z_d     = z_q;      p_d     = p_q;     g_d   = g_q;    u_d    = u_q;
    pl_d    = pl_q;     pr_d    = pr_q;    pleft_d = pleft_q;
    rx_d    = rx_q;     ry_d    = ry_q;    rb_d  = rb_q;   rxp_d  = rxp_q;
    rr_d    = rr_q;     ret_d   = ret_q;
    rslot_d = rslot_q;  rnew_d  = rnew_q;  rfull_d = rfull_q;
    rd_en   = 1'b0;     rd_addr = NIL;
    wr_en   = 1'b0;     wr_mask = '0;      wr_addr = NIL;
    wr_left = NIL;      wr_right = NIL;    wr_parent = NIL; wr_red = 1'b0;
    ychild  = rr_q ? rd_right : rd_left;

    case (state_q)
      ST_IDLE: begin
        if (req_i.valid) begin
          key_d  = req_i.key[KEY_BITS-1:0];
          par_d  = NIL;
          left_d = 1'b0;
          if (root_q == NIL) begin
            state_d = ST_INS;
          end else begin
            rd_en   = 1'b1;
            rd_addr = root_q;
            cur_d   = root_q;
            state_d = ST_SRCH;
          end
        end
      end
      ST_SRCH: begin
        if (key_q == rd_key) begin
          rslot_d = cur_q;  rnew_d = 1'b0;  rfull_d = 1'b0;
          state_d = ST_DONE;
        end else begin
          par_d  = cur_q;
          left_d = key_q < rd_key;
          if (nxt == NIL) begin
            state_d = ST_INS;
          end else begin
            rd_en   = 1'b1;
            rd_addr = nxt;
            cur_d   = nxt;
          end
        end
      end
      ST_INS: begin
        if (count_q == NIL) begin
          rslot_d = '0;  rnew_d = 1'b0;  rfull_d = 1'b1;
          state_d = ST_DONE;
        end else begin
          wr_en     = 1'b1;
          wr_mask   = '{key: 1'b1, left: 1'b1, right: 1'b1, parent: 1'b1, red: 1'b1};
          wr_addr   = count_q;
          wr_parent = par_q;
          wr_red    = 1'b1;
          state_d   = ST_LINK;
        end
      end
      ST_LINK: begin
        if (par_q == NIL) begin
          root_d = count_q;
        end else begin
          wr_en        = 1'b1;
          wr_addr      = par_q;
          wr_mask.left = left_q;
          wr_mask.right = !left_q;
          wr_left      = count_q;
          wr_right     = count_q;
        end
        rslot_d = count_q;  rnew_d = 1'b1;  rfull_d = 1'b0;
        z_d     = count_q;
        count_d = count_q + 1'b1;
        state_d = ST_FZ;
      end
      // Fix-up loop: fetch z, its parent, grandparent and uncle.
      ST_FZ: begin
        rd_en = 1'b1;  rd_addr = z_q;  state_d = ST_FP0;
      end
      ST_FP0: begin
        p_d = rd_parent;
        rd_en = 1'b1;  rd_addr = rd_parent;  state_d = ST_FP;
      end
      ST_FP: begin
        pl_d = rd_left;  pr_d = rd_right;  g_d = rd_parent;
        if (!rd_red || rd_parent == NIL) begin
          state_d = ST_ROOT;
        end else begin
          rd_en = 1'b1;  rd_addr = rd_parent;  state_d = ST_FG;
        end
      end
      ST_FG: begin
        pleft_d = (p_q == rd_left);
        u_d     = (p_q == rd_left) ? rd_right : rd_left;
        rd_en   = 1'b1;
        rd_addr = (p_q == rd_left) ? rd_right : rd_left;
        state_d = ST_FU;
      end
      ST_FU: begin
        if (rd_red) begin
          wr_en = 1'b1;  wr_mask.red = 1'b1;  wr_addr = p_q;  wr_red = 1'b0;
          state_d = ST_RC1;
        end else if (pleft_q ? (z_q == pr_q) : (z_q == pl_q)) begin
          // Inner grandchild: rotate at the parent first.
          z_d   = p_q;
          rx_d  = p_q;
          rr_d  = !pleft_q;
          ret_d = 1'b1;
          state_d = ST_R0;
        end else begin
          state_d = ST_CW1;
        end
      end
      ST_RC1: begin
        wr_en = 1'b1;  wr_mask.red = 1'b1;  wr_addr = u_q;  wr_red = 1'b0;
        state_d = ST_RC2;
      end
      ST_RC2: begin
        wr_en = 1'b1;  wr_mask.red = 1'b1;  wr_addr = g_q;  wr_red = 1'b1;
        z_d = g_q;
        state_d = ST_FZ;
      end
      ST_CW1: begin
        wr_en = 1'b1;  wr_mask.red = 1'b1;  wr_addr = p_q;  wr_red = 1'b0;
        state_d = ST_CW2;
      end
      ST_CW2: begin
        wr_en = 1'b1;  wr_mask.red = 1'b1;  wr_addr = g_q;  wr_red = 1'b1;
        rx_d  = g_q;
        rr_d  = pleft_q;
        ret_d = 1'b0;
        state_d = ST_R0;
      end
      // Rotation of rx_q: right rotation when rr_q is set, else left.
      ST_R0: begin
        rd_en = 1'b1;  rd_addr = rx_q;  state_d = ST_R1;
      end
      ST_R1: begin
        rxp_d = rd_parent;
        ry_d  = rr_q ? rd_left : rd_right;
        if ((rr_q ? rd_left : rd_right) == NIL) begin
          p_d     = rd_parent;
          state_d = ret_q ? ST_CW1 : ST_ROOT;
        end else begin
          rd_en   = 1'b1;
          rd_addr = rr_q ? rd_left : rd_right;
          state_d = ST_R2;
        end
      end
      ST_R2: begin
        rb_d          = ychild;
        wr_en         = 1'b1;
        wr_addr       = rx_q;
        wr_mask.left  = rr_q;
        wr_mask.right = !rr_q;
        wr_left       = ychild;
        wr_right      = ychild;
        state_d       = ST_R3;
      end
      ST_R3: begin
        wr_en = 1'b1;  wr_mask.parent = 1'b1;  wr_addr = rb_q;  wr_parent = rx_q;
        state_d = ST_R4;
      end
      ST_R4: begin
        wr_en = 1'b1;  wr_mask.parent = 1'b1;  wr_addr = ry_q;  wr_parent = rxp_q;
        state_d = ST_R5;
      end
      ST_R5: begin
        if (rxp_q == NIL) begin
          root_d  = ry_q;
          state_d = ST_R7;
        end else begin
          rd_en = 1'b1;  rd_addr = rxp_q;  state_d = ST_R6;
        end
      end
      ST_R6: begin
        wr_en         = 1'b1;
        wr_addr       = rxp_q;
        wr_mask.left  = (rd_left == rx_q);
        wr_mask.right = (rd_left != rx_q);
        wr_left       = ry_q;
        wr_right      = ry_q;
        state_d       = ST_R7;
      end
      ST_R7: begin
        wr_en         = 1'b1;
        wr_addr       = ry_q;
        wr_mask.left  = !rr_q;
        wr_mask.right = rr_q;
        wr_left       = rx_q;
        wr_right      = rx_q;
        state_d       = ST_R8;
      end
      ST_R8: begin
        wr_en = 1'b1;  wr_mask.parent = 1'b1;  wr_addr = rx_q;  wr_parent = ry_q;
        p_d     = ry_q;
        state_d = ret_q ? ST_CW1 : ST_ROOT;
      end
      ST_ROOT: begin
        wr_en = 1'b1;  wr_mask.red = 1'b1;  wr_addr = root_q;  wr_red = 1'b0;
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_load) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      chunk_q     <= '0;
      root_q      <= NIL;
      count_q     <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      root_q  <= root_d;
      count_q <= count_d;
      if (cfg_we_i) chunk_q <= cfg_data_i;
      if (res_load) res_valid_q <= 1'b1;
      else if (res_o.ready) res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;  cur_q <= cur_d;  par_q <= par_d;  left_q <= left_d;
    z_q   <= z_d;    p_q   <= p_d;    g_q   <= g_d;    u_q    <= u_d;
    pl_q  <= pl_d;   pr_q  <= pr_d;   pleft_q <= pleft_d;
    rx_q  <= rx_d;   ry_q  <= ry_d;   rb_q  <= rb_d;   rxp_q  <= rxp_d;
    rr_q  <= rr_d;   ret_q <= ret_d;
    rslot_q <= rslot_d;  rnew_q <= rnew_d;  rfull_q <= rfull_d;
    if (res_load) begin
      res_slot_q <= rslot_q[SlotW-1:0];
      res_off_q  <= OffW'(32'(rslot_q) * 32'(chunk_q));
      res_new_q  <= rnew_q;
      res_full_q <= rfull_q;
    end
  end

endmodule
